// ===== hdl/ttwb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttwb_pkg
// shared widths, codes and helpers of the terrain texture weight blend core
// ----------------------------------------------------------------------------
`default_nettype none

package ttwb_pkg;

  // field widths
  localparam int HW   = 24;               // heights and elevations, 1/256 m
  localparam int PW   = 8;                // grid position
  localparam int WW   = 17;               // Q1.16 weights
  localparam int NREG = 8;
  localparam int IDXW = $clog2(NREG);

  // ramp arithmetic: heights scaled by 8 stay exact
  localparam int NW   = HW + 6;           // signed ramp offsets
  localparam int REMW = HW + 2;           // divider remainder
  localparam int DVW  = HW;               // positive ramp half width
  localparam int QW   = WW;               // ramp quotient bits

  // blend
  localparam int GRID_W    = 256;
  localparam int GRID_R    = 256;
  localparam int CW        = $clog2(GRID_W + 1);
  localparam int KW        = 2 * CW;
  localparam int DEN_SHIFT = $clog2(GRID_W * GRID_R);
  localparam int MW        = DEN_SHIFT + WW;

  // pipeline depth
  localparam int CORNER_LAT = QW + 2;
  localparam int LATENCY    = CORNER_LAT + 3;

  localparam logic [WW-1:0] ONE_Q16  = WW'(65536);
  localparam logic [WW-1:0] HALF_Q16 = WW'(32768);

  localparam logic signed [HW-1:0] LOW_RESET  = HW'(2560);
  localparam logic signed [HW-1:0] HIGH_RESET = HW'(15360);

  typedef enum logic [IDXW-1:0] {
    REG_LOW_NW, REG_HIGH_NW, REG_LOW_NE, REG_HIGH_NE,
    REG_LOW_SW, REG_HIGH_SW, REG_LOW_SE, REG_HIGH_SE
  } reg_idx_t;

  // texture slots inside a weight set
  localparam int T_DIRT     = 0;
  localparam int T_GRASS    = 1;
  localparam int T_MOUNTAIN = 2;
  localparam int T_ROCK     = 3;

  // where the height falls for one corner
  typedef enum logic [2:0] {
    K_DIRT, K_BAND0, K_GRASS, K_BAND1, K_MTN, K_BAND2, K_ROCK, K_HALF
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [QW-1:0]   ramp;
  } corner_res_t;

  typedef logic [3:0][WW-1:0] wset_t;

  // normalized weight set of one corner from its region and ramp value
  function automatic wset_t corner_w(kind_t k, logic [QW-1:0] r);
    wset_t         w;
    logic [WW-1:0] rc;
    rc = ONE_Q16 - r;
    w  = '0;
    unique case (k)
      K_DIRT:  w[T_DIRT] = ONE_Q16;
      K_BAND0: begin
        w[T_DIRT]  = rc;
        w[T_GRASS] = r;
      end
      K_GRASS: w[T_GRASS] = ONE_Q16;
      K_BAND1: begin
        w[T_GRASS]    = rc;
        w[T_MOUNTAIN] = r;
      end
      K_MTN:   w[T_MOUNTAIN] = ONE_Q16;
      K_BAND2: begin
        w[T_MOUNTAIN] = rc;
        w[T_ROCK]     = r;
      end
      K_ROCK:  w[T_ROCK] = ONE_Q16;
      K_HALF:  begin
        w[T_DIRT] = HALF_Q16;
        w[T_ROCK] = HALF_Q16;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ttwb_corner.sv =====
// ----------------------------------------------------------------------------
// ttwb_corner
// ramp classification and pipelined ramp division for one region corner
// ----------------------------------------------------------------------------
`default_nettype none

module ttwb_corner (
  input  logic                           clk,
  input  logic signed [ttwb_pkg::HW-1:0] hs,
  input  logic signed [ttwb_pkg::HW-1:0] lo,
  input  logic signed [ttwb_pkg::HW-1:0] hi,
  output ttwb_pkg::corner_res_t          res
);
  import ttwb_pkg::*;

  // stage 1: offsets from the three ramp starts
  logic signed [HW:0]   d25;
  logic signed [HW:0]   lh_sum;
  logic signed [NW-1:0] h8, c0, c1, c2, dx;
  logic signed [NW-1:0] n0, n1, n2;
  logic signed [HW:0]   d;

  assign d25    = {hi[HW-1], hi} - {lo[HW-1], lo};
  assign lh_sum = {hi[HW-1], hi} + {lo[HW-1], lo};
  assign h8     = {{(NW-HW-3){hs[HW-1]}}, hs, 3'b000};
  assign c0     = {{(NW-HW-3){lo[HW-1]}}, lo, 3'b000};
  assign c2     = {{(NW-HW-3){hi[HW-1]}}, hi, 3'b000};
  assign c1     = {{(NW-HW-3){lh_sum[HW]}}, lh_sum, 2'b00};
  assign dx     = {{(NW-HW-1){d25[HW]}}, d25};

  always_ff @(posedge clk) begin
    n0 <= h8 - c0 + dx;
    n1 <= h8 - c1 + dx;
    n2 <= h8 - c2 + dx;
    d  <= d25;
  end

  // stage 2: region select
  logic signed [NW-1:0] twod;
  kind_t                kind_c;
  logic [REMW-1:0]      num_c;
  logic                 dirt_f, rock_f;

  assign twod = {{(NW-HW-2){d[HW]}}, d, 1'b0};

  always_comb begin
    kind_c = K_ROCK;
    num_c  = '0;
    dirt_f = n0[NW-1];
    rock_f = (d == '0) ? !dirt_f : !n2[NW-1];
    if (!d[HW] && (d != '0)) begin
      priority if (n0[NW-1]) begin
        kind_c = K_DIRT;
      end else if (n0 <= twod) begin
        kind_c = K_BAND0;
        num_c  = n0[REMW-1:0];
      end else if (n1[NW-1]) begin
        kind_c = K_GRASS;
      end else if (n1 <= twod) begin
        kind_c = K_BAND1;
        num_c  = n1[REMW-1:0];
      end else if (n2[NW-1]) begin
        kind_c = K_MTN;
      end else if (n2 <= twod) begin
        kind_c = K_BAND2;
        num_c  = n2[REMW-1:0];
      end else begin
        kind_c = K_ROCK;
      end
    end else begin
      // flat or inverted ramps: hard steps, both may hold
      priority if (dirt_f && rock_f) begin
        kind_c = K_HALF;
      end else if (dirt_f) begin
        kind_c = K_DIRT;
      end else begin
        kind_c = K_ROCK;
      end
    end
  end

  // divider stages: one quotient bit each, offset * 2^15 / half width
  kind_t            knd [0:QW];
  logic [REMW-1:0]  rem [0:QW];
  logic [DVW-1:0]   dvs [0:QW];
  logic [QW-1:0]    quo [0:QW];

  always_ff @(posedge clk) begin
    knd[0] <= kind_c;
    rem[0] <= num_c;
    dvs[0] <= d[DVW-1:0];
    quo[0] <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [REMW-1:0] t, dv;
    logic [REMW:0]   diff;
    logic            qbit;

    // step 0 weighs twice the divisor, from step 2 the remainder shifts
    assign t    = (k >= 2) ? {rem[k][REMW-2:0], 1'b0} : rem[k];
    assign dv   = (k == 0) ? {1'b0, dvs[k], 1'b0} : {2'b00, dvs[k]};
    assign diff = {1'b0, t} - {1'b0, dv};
    assign qbit = !diff[REMW];

    always_ff @(posedge clk) begin
      knd[k+1] <= knd[k];
      rem[k+1] <= qbit ? diff[REMW-1:0] : t;
      dvs[k+1] <= dvs[k];
      quo[k+1] <= {quo[k][QW-2:0], qbit};
    end
  end

  assign res = '{kind: knd[QW], ramp: quo[QW]};

endmodule

`default_nettype wire

// ===== hdl/terrain_texture_weight_blend_core.sv =====
// ----------------------------------------------------------------------------
// terrain_texture_weight_blend_core
// height driven dirt/grass/mountain/rock splat weights, blended over 4 corners
// ----------------------------------------------------------------------------
// usage
//   start with busy low moves one sample transaction in: grid_x, grid_y and
//   height_sample. busy is a registered copy of rst.
//   every accepted sample gives exactly one result: done pulses for one cycle
//   with the four Q1.16 weights; results leave in the order samples entered
//   the path runs through 2 classify stages, 17 divider stages (one
//   quotient bit per stage, per corner), then weight select, multiply
//   and sum stages
//   throughput is one sample per cycle while busy is low, samples may come back to back
//   the receiver cannot stall; nothing waits on it
//   cfg_write stores cfg_data into register cfg_index (low/high elevation of
//   nw, ne, sw, se in that order); write only while no sample is in flight
//   reset (synchronous) loads elevations 2560 / 15360 and flushes the
//   pipeline, so no done follows reset until a new sample enters
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_texture_weight_blend_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ttwb_pkg::PW-1:0]          grid_x,
  input  logic [ttwb_pkg::PW-1:0]          grid_y,
  input  logic signed [ttwb_pkg::HW-1:0]   height_sample,
  input  logic                             cfg_write,
  input  logic [ttwb_pkg::IDXW-1:0]        cfg_index,
  input  logic [ttwb_pkg::HW-1:0]          cfg_data,
  output logic                             done,
  output logic [ttwb_pkg::WW-1:0]          weight_dirt,
  output logic [ttwb_pkg::WW-1:0]          weight_grass,
  output logic [ttwb_pkg::WW-1:0]          weight_mountain,
  output logic [ttwb_pkg::WW-1:0]          weight_rock
);
  import ttwb_pkg::*;

  // elevation registers
  logic signed [HW-1:0] cfg_reg [0:NREG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        cfg_reg[i] <= ((i % 2) == 1) ? HIGH_RESET : LOW_RESET;
      end
    end else if (cfg_write) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // accept and valid tracking
  logic                accept;
  logic [LATENCY-1:0]  vld;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  assign done = vld[LATENCY-1];

  // corner ramps, order nw, ne, sw, se
  corner_res_t res [0:3];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    ttwb_corner u_corner (
      .clk (clk),
      .hs  (height_sample),
      .lo  (cfg_reg[2*c]),
      .hi  (cfg_reg[2*c+1]),
      .res (res[c])
    );
  end

  // position travels alongside the corner pipelines
  logic [PW-1:0] xp [0:CORNER_LAT-1];
  logic [PW-1:0] yp [0:CORNER_LAT-1];

  always_ff @(posedge clk) begin
    xp[0] <= grid_x;
    yp[0] <= grid_y;
    for (int i = 1; i < CORNER_LAT; i++) begin
      xp[i] <= xp[i-1];
      yp[i] <= yp[i-1];
    end
  end

  // weight select and bilinear coefficients
  logic [CW-1:0] ax, bx, ay, by;
  logic [KW-1:0] coef [0:3];
  wset_t         wt   [0:3];

  assign ax = {1'b0, xp[CORNER_LAT-1]};
  assign ay = {1'b0, yp[CORNER_LAT-1]};
  assign bx = CW'(GRID_W) - ax;
  assign by = CW'(GRID_R) - ay;

  always_ff @(posedge clk) begin
    coef[0] <= bx * ay;   // nw
    coef[1] <= ax * ay;   // ne
    coef[2] <= bx * by;   // sw
    coef[3] <= ax * by;   // se
    for (int c = 0; c < 4; c++) begin
      wt[c] <= corner_w(res[c].kind, res[c].ramp);
    end
  end

  // products, one per corner and texture
  logic [MW-1:0] prod [0:3][0:3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prod[c][t] <= {{(MW-KW){1'b0}}, coef[c]} * {{(MW-WW){1'b0}}, wt[c][t]};
      end
    end
  end

  // sum over corners, divide by grid area; total never exceeds one
  logic [MW-1:0] acc [0:3];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      acc[t] = prod[0][t] + prod[1][t] + prod[2][t] + prod[3][t];
    end
  end

  always_ff @(posedge clk) begin
    weight_dirt     <= acc[T_DIRT][DEN_SHIFT +: WW];
    weight_grass    <= acc[T_GRASS][DEN_SHIFT +: WW];
    weight_mountain <= acc[T_MOUNTAIN][DEN_SHIFT +: WW];
    weight_rock     <= acc[T_ROCK][DEN_SHIFT +: WW];
  end

endmodule

`default_nettype wire

// ===== hdl/ttwb_checker.sv =====
// ----------------------------------------------------------------------------
// ttwb_checker
// port level checks of the terrain texture weight blend core
// ----------------------------------------------------------------------------
`default_nettype none

module ttwb_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [ttwb_pkg::WW-1:0] weight_dirt,
  input logic [ttwb_pkg::WW-1:0] weight_grass,
  input logic [ttwb_pkg::WW-1:0] weight_mountain,
  input logic [ttwb_pkg::WW-1:0] weight_rock
);
  import ttwb_pkg::*;

  logic [WW+1:0] wsum;

  assign wsum = {2'b00, weight_dirt} + {2'b00, weight_grass}
              + {2'b00, weight_mountain} + {2'b00, weight_rock};

  // every transaction returns after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted transaction");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // blended weights sum to one, less at most three flooring steps
  a_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (wsum >= (WW+2)'(65533)) && (wsum <= (WW+2)'(65536)))
    else $error("weights do not sum to one");

  a_reset: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("reset did not flush the pipeline");

endmodule

bind terrain_texture_weight_blend_core ttwb_checker u_ttwb_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .weight_dirt     (weight_dirt),
  .weight_grass    (weight_grass),
  .weight_mountain (weight_mountain),
  .weight_rock     (weight_rock)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the terrain texture weight blend core: drives
// sample transactions under several elevation settings, predicts the four
// blended texture weights per sample and compares every done strobe in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ttwb_pkg::*;

  // per-texture weights in full precision, dirt at slot 0
  typedef longint weight_quad_t [4];

  // --------------------------------------------------------------------------
  // weight scoreboard: keeps its own copy of the elevation registers and a
  // queue of predicted weight sets, oldest first
  // --------------------------------------------------------------------------
  class splat_scoreboard;
    longint        elev [NREG];
    wset_t         expected_weights [$];
    int            mismatches;

    function new();
      mismatches = 0;
      for (int i = 0; i < NREG; i += 2) begin
        elev[i]     = 2560;
        elev[i + 1] = 15360;
      end
    endfunction

    function void set_elevation(int idx, logic signed [HW-1:0] val);
      elev[idx] = longint'(val);
    endfunction

    // rising ramp at centre c with half width d, Q16, clamped to 0..one
    function longint ramp_rise(longint h, longint c, longint d);
      longint q;
      q = ((h - c + d) * 65536) / (2 * d);
      if (q < 0) q = 0;
      if (q > 65536) q = 65536;
      return q;
    endfunction

    function weight_quad_t corner_split(longint hs, longint lo, longint hi);
      weight_quad_t w;
      longint h, c0, c1, c2, d, tot;
      h  = hs * 8;
      c0 = lo * 8;
      c1 = (lo + hi) * 4;
      c2 = hi * 8;
      d  = hi - lo;
      if (d == 0) begin
        // hard step at the single elevation
        w[0] = (h < c0) ? 65536 : 0;
        w[1] = 0;
        w[2] = 0;
        w[3] = (h >= c0) ? 65536 : 0;
      end else begin
        if (h < c0 - d)      w[0] = 65536;
        else if (h > c0 + d) w[0] = 0;
        else                 w[0] = 65536 - ramp_rise(h, c0, d);

        if (h < c0 - d)                      w[1] = 0;
        else if (h > c1 + d)                 w[1] = 0;
        else if (h >= c0 - d && h <= c0 + d) w[1] = ramp_rise(h, c0, d);
        else if (h >= c1 - d && h <= c1 + d) w[1] = 65536 - ramp_rise(h, c1, d);
        else                                 w[1] = 65536;

        if (h < c1 - d)                      w[2] = 0;
        else if (h > c2 + d)                 w[2] = 0;
        else if (h >= c1 - d && h <= c1 + d) w[2] = ramp_rise(h, c1, d);
        else if (h >= c2 - d && h <= c2 + d) w[2] = 65536 - ramp_rise(h, c2, d);
        else                                 w[2] = 65536;

        if (h < c2 - d)      w[3] = 0;
        else if (h > c2 + d) w[3] = 65536;
        else                 w[3] = ramp_rise(h, c2, d);
      end
      tot = w[0] + w[1] + w[2] + w[3];
      if (tot <= 0) begin
        // nothing positive: pure grass
        w[0] = 0; w[1] = 65536; w[2] = 0; w[3] = 0;
      end else begin
        for (int i = 0; i < 4; i++) w[i] = (w[i] * 65536) / tot;
      end
      return w;
    endfunction

    // accepted sample: bilinear blend of the four corner splits
    function void note_sample(logic [PW-1:0] gx, logic [PW-1:0] gy,
                              logic signed [HW-1:0] hgt);
      weight_quad_t nw, ne, sw, se;
      wset_t        res;
      longint       ax, bx, ay, by, acc, v, hs;
      hs = longint'(hgt);
      nw = corner_split(hs, elev[REG_LOW_NW], elev[REG_HIGH_NW]);
      ne = corner_split(hs, elev[REG_LOW_NE], elev[REG_HIGH_NE]);
      sw = corner_split(hs, elev[REG_LOW_SW], elev[REG_HIGH_SW]);
      se = corner_split(hs, elev[REG_LOW_SE], elev[REG_HIGH_SE]);
      ax = gx;
      ay = gy;
      bx = (GRID_W > ax) ? GRID_W - ax : 0;
      by = (GRID_R > ay) ? GRID_R - ay : 0;
      for (int i = 0; i < 4; i++) begin
        acc = bx * by * sw[i] + ax * by * se[i] + bx * ay * nw[i] + ax * ay * ne[i];
        v = acc / (GRID_W * GRID_R);
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        res[i] = WW'(v);
      end
      expected_weights.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_weights(wset_t got);
      wset_t want;
      string names [4];
      names = '{"dirt", "grass", "mountain", "rock"};
      if (expected_weights.size() == 0) begin
        report("result strobe with no sample outstanding");
      end else begin
        want = expected_weights.pop_front();
        for (int i = 0; i < 4; i++)
          if (got[i] !== want[i])
            report($sformatf("weight_%s got %0d want %0d", names[i], got[i], want[i]));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block signals
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [PW-1:0]        grid_x = '0;
  logic [PW-1:0]        grid_y = '0;
  logic signed [HW-1:0] height_sample = '0;
  logic                 cfg_write = 1'b0;
  logic [IDXW-1:0]      cfg_index = '0;
  logic [HW-1:0]        cfg_data = '0;
  logic                 done;
  logic [WW-1:0]        weight_dirt, weight_grass, weight_mountain, weight_rock;

  splat_scoreboard sb = new();
  bit              idle_enable;

  always #5 clk = ~clk;

  terrain_texture_weight_blend_core dut (
    .clk, .rst, .start, .busy, .grid_x, .grid_y, .height_sample,
    .cfg_write, .cfg_index, .cfg_data,
    .done, .weight_dirt, .weight_grass, .weight_mountain, .weight_rock
  );

  // monitor: register writes, accepted sample transactions and results are
  // all taken from values present before the edge
  always @(posedge clk) begin
    if (!rst && cfg_write) sb.set_elevation(cfg_index, cfg_data);
    if (!rst && start && !busy) sb.note_sample(grid_x, grid_y, height_sample);
    if (!rst && done)
      sb.check_weights({weight_rock, weight_mountain, weight_grass, weight_dirt});
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  // one sample transaction; start stays high when the next call follows
  task send_sample(logic [PW-1:0] gx, logic [PW-1:0] gy, logic signed [HW-1:0] hgt);
    int gap;
    cfg_write     <= 1'b0;
    start         <= 1'b1;
    grid_x        <= gx;
    grid_y        <= gy;
    height_sample <= hgt;
    @(posedge clk);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start         <= 1'b0;
      height_sample <= HW'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // write enable stays high until the next sample transaction drops it
  task write_reg(reg_idx_t idx, longint val);
    start     <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= HW'(val);
    @(posedge clk);
  endtask

  // idle the block: drain every outstanding result, then the pipeline depth
  task wait_drained();
    start <= 1'b0;
    while (sb.expected_weights.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task set_corner(reg_idx_t lo_idx, reg_idx_t hi_idx, longint lo, longint hi);
    write_reg(lo_idx, lo);
    write_reg(hi_idx, hi);
  endtask

  function automatic longint sat24(longint v);
    if (v < -8388608) return -8388608;
    if (v > 8388607) return 8388607;
    return v;
  endfunction

  // random elevation pair; flavor picks ordered, flat, inverted or extreme
  function automatic void pick_pair(int flavor, output longint lo, output longint hi);
    longint base, span;
    base = longint'($urandom_range(0, 40000)) - 20000;
    span = $urandom_range(1, 30000);
    case (flavor)
      0: begin lo = base; hi = base + span; end
      1: begin lo = base; hi = base; end
      2: begin lo = base + span; hi = base; end
      default: begin lo = -8388608; hi = 8388607; end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    longint lo, hi, lo_min, hi_max, hgt;
    int     flavor, n_items;
    reg_idx_t lo_ids [4], hi_ids [4];
    lo_ids = '{REG_LOW_NW, REG_LOW_NE, REG_LOW_SW, REG_LOW_SE};
    hi_ids = '{REG_HIGH_NW, REG_HIGH_NE, REG_HIGH_SW, REG_HIGH_SE};
    idle_enable = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed, reset elevations: band edges, extremes of height and position
    send_sample(8'd0,   8'd0,   24'sd0);
    send_sample(8'd255, 8'd255, -24'sd8388608);
    send_sample(8'd0,   8'd255, 24'sd8388607);
    send_sample(8'd255, 8'd0,   24'sd960);     // lower edge of the dirt band
    send_sample(8'd128, 8'd128, 24'sd2560);    // dirt/grass centre
    send_sample(8'd17,  8'd200, 24'sd4160);    // top of the dirt band
    send_sample(8'd99,  8'd3,   24'sd8960);    // grass/mountain centre
    send_sample(8'd250, 8'd77,  24'sd15360);   // mountain/rock centre
    send_sample(8'd1,   8'd1,   24'sd16960);   // top of the rock band
    send_sample(8'd170, 8'd85,  24'sd12000);
    wait_drained();

    // directed, special corners: flat step, inverted, full-range ramp
    set_corner(REG_LOW_NW, REG_HIGH_NW, 5000, 5000);
    set_corner(REG_LOW_NE, REG_HIGH_NE, 9000, 1000);
    set_corner(REG_LOW_SW, REG_HIGH_SW, -8388608, 8388607);
    set_corner(REG_LOW_SE, REG_HIGH_SE, 8388607, -8388608);
    send_sample(8'd255, 8'd255, 24'sd4999);    // just under the flat step
    send_sample(8'd255, 8'd255, 24'sd5000);    // at the flat step
    send_sample(8'd0,   8'd255, 24'sd5000);    // nw flat step holds most weight
    send_sample(8'd0,   8'd255, 24'sd500);
    send_sample(8'd0,   8'd0,   -24'sd8388608);
    send_sample(8'd0,   8'd0,   24'sd8388607);
    send_sample(8'd255, 8'd0,   24'sd0);       // inverted se corner, zero height
    send_sample(8'd200, 8'd60,  24'sd9000);
    wait_drained();

    // random phases, each under a fresh elevation setting
    idle_enable = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      lo_min = 8388607;
      hi_max = -8388608;
      for (int c = 0; c < 4; c++) begin
        flavor = (ph == 7) ? 3 : ($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
        pick_pair(flavor, lo, hi);
        if (ph == 0) begin lo = 2560; hi = 15360; end
        set_corner(lo_ids[c], hi_ids[c], lo, hi);
        if (lo < lo_min) lo_min = lo;
        if (hi < lo_min) lo_min = hi;
        if (hi > hi_max) hi_max = hi;
        if (lo > hi_max) hi_max = lo;
      end
      if (ph == 6) idle_enable = 1'b0;   // closing stretch runs back to back
      n_items = 90;
      for (int k = 0; k < n_items; k++) begin
        // most heights near the configured bands, some over the full range
        if ($urandom_range(0, 9) < 8)
          hgt = sat24(lo_min - 4000 + longint'($urandom_range(0,
                      int'(hi_max - lo_min + 8000 > 2000000000 ? 2000000000
                           : hi_max - lo_min + 8000))));
        else
          hgt = longint'(signed'(HW'($urandom)));
        send_sample(PW'($urandom), PW'($urandom), HW'(hgt));
      end
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.expected_weights.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
